FILE: rtl/core/wtsp_pkg.sv
// Package with shared types and constants of the world-to-screen projection block.
`timescale 1ns / 1ps
package wtsp_pkg;
    localparam int CLIP_W     = 49;
    localparam int MAG_W      = 48;
    localparam int Q_W        = 41;
    localparam int N_W        = Q_W + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int CFG_W      = 64;
    localparam int SIZE_W     = 14;
    localparam int NUM_ROWS   = 6;

    localparam logic signed [CLIP_W-1:0] BEHIND_MAX = 49'sd6553;
    localparam logic signed [31:0]       ON_MIN     = 32'sd6554;
    localparam logic [Q_W-1:0]           NORM_CLAMP = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [2:0] {
        CFG_ROW_X_A   = 3'd0,
        CFG_ROW_X_B   = 3'd1,
        CFG_ROW_Y_A   = 3'd2,
        CFG_ROW_Y_B   = 3'd3,
        CFG_ROW_D_A   = 3'd4,
        CFG_ROW_D_B   = 3'd5,
        CFG_WIDTH     = 3'd6,
        CFG_HEIGHT    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cd;
        logic                     behind;
    } t_clip;
endpackage

FILE: rtl/core/wtsp_in_if.sv
// Input channel interface carrying one world-space point.
`timescale 1ns / 1ps
interface wtsp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

FILE: rtl/core/wtsp_out_if.sv
// Output channel interface carrying one projected screen point.
`timescale 1ns / 1ps
interface wtsp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               behind_camera;
    logic               on_screen;
    modport source (output valid, screen_x, screen_y, behind_camera, on_screen, input ready);
    modport sink (input valid, screen_x, screen_y, behind_camera, on_screen, output ready);
endinterface

FILE: rtl/core/world_to_screen_projection_top.sv
// Top level of the world-to-screen projection block with its configuration registers.
//
// Points enter on i_pt (valid/ready) as signed Q16.16 world coordinates; projected
// pixels leave on o_pix (valid/ready) as signed Q16.16 screen coordinates plus the
// behind_camera and on_screen flags. One transaction moves at each edge where valid
// and ready are both high, and one point can be accepted in every clock cycle while
// the queue has room. A point passes two multiply/sum stages, the queue, a 42-stage
// restoring divider (an input stage, then one quotient bit per stage, x and y lanes
// side by side) and two viewport stages. The matrix rows and viewport size are
// written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must write them only
// while no point is in flight; the block does not enforce this. Reset clears all
// pipeline valid bits and the queue, sets the matrix to zero and the viewport to
// 1920 by 1080. When the receiver holds ready low, the back end freezes, the queue
// fills, and then the front end drops i_pt.ready; no transaction is lost or repeated.
`timescale 1ns / 1ps
module world_to_screen_projection_top #(
    parameter int FIFO_DEPTH = wtsp_pkg::FIFO_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [wtsp_pkg::CFG_W-1:0] i_cfg_data,
    wtsp_in_if.sink                    i_pt,
    wtsp_out_if.source                 o_pix
);
    logic [wtsp_pkg::NUM_ROWS-1:0][wtsp_pkg::CFG_W-1:0] r_rows;
    logic [wtsp_pkg::SIZE_W-1:0] r_w, r_h;
    logic            push, pop, full, empty;
    wtsp_pkg::t_clip f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
            r_w    <= wtsp_pkg::SIZE_W'(1920);
            r_h    <= wtsp_pkg::SIZE_W'(1080);
        end else if (i_cfg_we) begin
            case (wtsp_pkg::t_cfg_idx'(i_cfg_idx))
                wtsp_pkg::CFG_ROW_X_A: r_rows[0] <= i_cfg_data;
                wtsp_pkg::CFG_ROW_X_B: r_rows[1] <= i_cfg_data;
                wtsp_pkg::CFG_ROW_Y_A: r_rows[2] <= i_cfg_data;
                wtsp_pkg::CFG_ROW_Y_B: r_rows[3] <= i_cfg_data;
                wtsp_pkg::CFG_ROW_D_A: r_rows[4] <= i_cfg_data;
                wtsp_pkg::CFG_ROW_D_B: r_rows[5] <= i_cfg_data;
                wtsp_pkg::CFG_WIDTH:   r_w <= i_cfg_data[wtsp_pkg::SIZE_W-1:0];
                wtsp_pkg::CFG_HEIGHT:  r_h <= i_cfg_data[wtsp_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wtsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_rows  (r_rows),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    wtsp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (q_item)
    );

    wtsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_item  (q_item),
        .o_pop   (pop),
        .i_w     (r_w),
        .i_h     (r_h),
        .o_pix   (o_pix)
    );
endmodule

FILE: rtl/core/wtsp_front.sv
// Front end: accepts points and forms the three matrix-row dot products.
`timescale 1ns / 1ps
module wtsp_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    wtsp_in_if.sink                                  i_pt,
    input  logic [wtsp_pkg::NUM_ROWS-1:0][wtsp_pkg::CFG_W-1:0] i_rows,
    input  logic                                     i_full,
    output logic                                     o_push,
    output wtsp_pkg::t_clip                          o_item
);
    logic               en;
    logic               r_v1, r_v2;
    logic signed [63:0] r_p [9];
    logic signed [63:0] n_p [9];
    logic signed [31:0] coef [9];
    logic signed [31:0] offs [3];
    logic signed [wtsp_pkg::CLIP_W-1:0] n_sum [3];
    wtsp_pkg::t_clip    r_item;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            coef[3*r]   = $signed(i_rows[2*r][31:0]);
            coef[3*r+1] = $signed(i_rows[2*r][63:32]);
            coef[3*r+2] = $signed(i_rows[2*r+1][31:0]);
            offs[r]     = $signed(i_rows[2*r+1][63:32]);
        end
        for (int r = 0; r < 3; r++) begin
            n_p[3*r]   = coef[3*r] * i_pt.world_x;
            n_p[3*r+1] = coef[3*r+1] * i_pt.world_y;
            n_p[3*r+2] = coef[3*r+2] * i_pt.world_z;
        end
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = 49'(r_p[3*r] >>> 16) + 49'(r_p[3*r+1] >>> 16)
                     + 49'(r_p[3*r+2] >>> 16) + 49'(offs[r]);
        end
    end

    assign en         = !r_v2 || !i_full;
    assign i_pt.ready = en;
    assign o_push     = r_v2 && !i_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pt.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_p[k] <= n_p[k];
            end
            r_item.cx     <= n_sum[0];
            r_item.cy     <= n_sum[1];
            r_item.cd     <= n_sum[2];
            r_item.behind <= (n_sum[2] <= wtsp_pkg::BEHIND_MAX);
        end
    end
endmodule

FILE: rtl/core/wtsp_fifo.sv
// Short queue between the front end and the back end.
`timescale 1ns / 1ps
module wtsp_fifo #(
    parameter int DEPTH = wtsp_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wtsp_pkg::t_clip i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output wtsp_pkg::t_clip o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wtsp_pkg::t_clip r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("Queue count exceeds depth.");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("Push into a full queue.");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("Pop from an empty queue.");
endmodule

FILE: rtl/core/wtsp_div.sv
// Pipelined restoring divider forming clip * 65536 / depth with clamping.
`timescale 1ns / 1ps
module wtsp_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [wtsp_pkg::CLIP_W-1:0]  i_clip,
    input  logic [wtsp_pkg::MAG_W-1:0]          i_den,
    output logic signed [wtsp_pkg::N_W-1:0]     o_n
);
    localparam int QW = wtsp_pkg::Q_W;
    localparam int MW = wtsp_pkg::MAG_W;

    logic [MW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic [MW-1:0] r_mag [QW+1];
    logic [MW-1:0] r_den [QW+1];
    logic          r_neg [QW+1];
    logic          r_ovf [QW+1];

    logic                           n_neg;
    logic [wtsp_pkg::CLIP_W-1:0]    n_abs;
    logic [MW-1:0]                  n_mag;
    logic [QW-1:0]                  q_fin;

    always_comb begin
        n_neg = i_clip[wtsp_pkg::CLIP_W-1];
        n_abs = n_neg ? -i_clip : i_clip;
        n_mag = n_abs[MW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0] <= n_mag;
            r_den[0] <= i_den;
            r_neg[0] <= n_neg;
            r_rem[0] <= MW'(n_mag[MW-1:QW-16]);
            r_q[0]   <= '0;
            r_ovf[0] <= (MW'(n_mag[MW-1:QW-16]) >= i_den);
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int BI = QW - k;
        logic          nbit;
        logic [MW:0]   t;
        logic [MW:0]   d;
        logic          ge;
        if (BI >= 16) begin : g_bit
            assign nbit = r_mag[k-1][BI-16];
        end else begin : g_zero
            assign nbit = 1'b0;
        end
        assign t  = {r_rem[k-1], nbit};
        assign ge = (t >= {1'b0, r_den[k-1]});
        assign d  = t - {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? d[MW-1:0] : t[MW-1:0];
                r_q[k]   <= r_q[k-1] | (QW'(ge) << BI);
                r_mag[k] <= r_mag[k-1];
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    always_comb begin
        q_fin = r_q[QW];
        if (r_ovf[QW] || (q_fin[QW-1] && (|q_fin[QW-2:0]))) begin
            q_fin = wtsp_pkg::NORM_CLAMP;
        end
        o_n = r_neg[QW] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
    end
endmodule

FILE: rtl/core/wtsp_back.sv
// Back end: normalizes by depth and maps to viewport pixels.
`timescale 1ns / 1ps
module wtsp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  wtsp_pkg::t_clip               i_item,
    output logic                          o_pop,
    input  logic [wtsp_pkg::SIZE_W-1:0]   i_w,
    input  logic [wtsp_pkg::SIZE_W-1:0]   i_h,
    wtsp_out_if.source                    o_pix
);
    localparam int DL = wtsp_pkg::Q_W + 1;
    localparam int PW = wtsp_pkg::N_W + wtsp_pkg::SIZE_W + 1;
    localparam int SW = PW + 2;

    logic                           en;
    logic                           r_vd [DL];
    logic                           r_bd [DL];
    logic signed [wtsp_pkg::N_W-1:0] nx, ny;
    logic                           r_vm, r_bm;
    logic signed [PW-1:0]           r_px, r_py;
    logic                           r_ov, r_beh, r_on;
    logic signed [31:0]             r_sx, r_sy;
    logic signed [SW-1:0]           fx, fy;
    logic signed [31:0]             n_sx, n_sy;
    logic signed [31:0]             wlim, hlim;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        if (v > SW'(32'sh7FFFFFFF)) begin
            return 32'sh7FFFFFFF;
        end else if (v < -(SW'(64'sh80000000))) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

    assign en    = !r_ov || o_pix.ready;
    assign o_pop = en && !i_empty;

    wtsp_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_clip (i_item.cx),
        .i_den  (i_item.cd[wtsp_pkg::MAG_W-1:0]),
        .o_n    (nx)
    );

    wtsp_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_clip (i_item.cy),
        .i_den  (i_item.cd[wtsp_pkg::MAG_W-1:0]),
        .o_n    (ny)
    );

    always_comb begin
        fx   = ($signed({2'b0, i_w, 16'b0}) + SW'(65536) + SW'(r_px)) >>> 1;
        fy   = ($signed({2'b0, i_h, 16'b0}) - SW'(65536) - SW'(r_py)) >>> 1;
        n_sx = sat32(fx);
        n_sy = sat32(fy);
        wlim = $signed({2'b0, i_w, 16'b0});
        hlim = $signed({2'b0, i_h, 16'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_vd[k] <= 1'b0;
            end
            r_vm <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vd[0] <= !i_empty;
            for (int k = 1; k < DL; k++) begin
                r_vd[k] <= r_vd[k-1];
            end
            r_vm <= r_vd[DL-1];
            r_ov <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bd[0] <= i_item.behind;
            for (int k = 1; k < DL; k++) begin
                r_bd[k] <= r_bd[k-1];
            end
            r_bm  <= r_bd[DL-1];
            r_px  <= nx * $signed({1'b0, i_w});
            r_py  <= ny * $signed({1'b0, i_h});
            r_beh <= r_bm;
            r_sx  <= r_bm ? '0 : n_sx;
            r_sy  <= r_bm ? '0 : n_sy;
            r_on  <= !r_bm && (n_sx >= wtsp_pkg::ON_MIN) && (n_sx <= wlim)
                     && (n_sy >= wtsp_pkg::ON_MIN) && (n_sy <= hlim);
        end
    end

    assign o_pix.valid         = r_ov;
    assign o_pix.screen_x      = r_sx;
    assign o_pix.screen_y      = r_sy;
    assign o_pix.behind_camera = r_beh;
    assign o_pix.on_screen     = r_on;

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_beh) |-> (r_sx == '0 && r_sy == '0 && !r_on))
        else $error("Point behind the camera has nonzero output.");
    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vm && en) |=> r_ov) else $error("Transaction lost before output.");
    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vd[0]) else $error("Popped transaction not tracked.");
endmodule

FILE: test/world_to_screen_projection_top_tb.sv
// Self-checking testbench for the world-to-screen projection block.
`timescale 1ns / 1ps
module world_to_screen_projection_top_tb;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic               behind;
        logic               on_scr;
    } t_pixel;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [2:0]                 i_cfg_idx = '0;
    logic [wtsp_pkg::CFG_W-1:0] i_cfg_data = '0;

    wtsp_in_if  pt_if();
    wtsp_out_if pix_if();

    world_to_screen_projection_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (pt_if.sink),
        .o_pix      (pix_if.source)
    );

    always #5 i_clk = ~i_clk;

    logic [63:0] matrix_regs [wtsp_pkg::NUM_ROWS];
    logic [13:0] view_w;
    logic [13:0] view_h;
    t_pixel      pixel_queue [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    initial begin
        pt_if.valid   = 1'b0;
        pt_if.world_x = '0;
        pt_if.world_y = '0;
        pt_if.world_z = '0;
        pix_if.ready  = 1'b0;
    end

    function automatic longint floor_q16(longint p);
        return p >>> 16;
    endfunction

    function automatic longint row_dot(logic [63:0] a, logic [63:0] b,
                                       longint x, longint y, longint z);
        longint cx;
        longint cy;
        longint cz;
        longint off;
        cx  = longint'($signed(a[31:0]));
        cy  = longint'($signed(a[63:32]));
        cz  = longint'($signed(b[31:0]));
        off = longint'($signed(b[63:32]));
        return floor_q16(cx * x) + floor_q16(cy * y) + floor_q16(cz * z) + off;
    endfunction

    function automatic longint divide_by_depth(longint clip, longint depth);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (clip < 0) ? 64'(-clip) : 64'(clip);
        q = (mag * 64'd65536) / 64'(depth);
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return (clip < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit within_view(longint s, longint size);
        return (s * 10 >= 65536) && (s <= size * 65536);
    endfunction

    function automatic t_pixel project_point(logic [31:0] wx, logic [31:0] wy,
                                             logic [31:0] wz);
        t_pixel r;
        longint x;
        longint y;
        longint z;
        longint cx;
        longint cy;
        longint cd;
        longint nx;
        longint ny;
        longint w;
        longint h;
        longint sx;
        longint sy;
        x = longint'($signed(wx));
        y = longint'($signed(wy));
        z = longint'($signed(wz));
        w = longint'(view_w);
        h = longint'(view_h);
        cx = row_dot(matrix_regs[wtsp_pkg::CFG_ROW_X_A],
                     matrix_regs[wtsp_pkg::CFG_ROW_X_B], x, y, z);
        cy = row_dot(matrix_regs[wtsp_pkg::CFG_ROW_Y_A],
                     matrix_regs[wtsp_pkg::CFG_ROW_Y_B], x, y, z);
        cd = row_dot(matrix_regs[wtsp_pkg::CFG_ROW_D_A],
                     matrix_regs[wtsp_pkg::CFG_ROW_D_B], x, y, z);
        if (cd * 10 <= 65536) begin
            r.sx = '0;
            r.sy = '0;
            r.behind = 1'b1;
            r.on_scr = 1'b0;
            return r;
        end
        nx = divide_by_depth(cx, cd);
        ny = divide_by_depth(cy, cd);
        sx = clamp32((w * 65536 + 65536 + nx * w) >>> 1);
        sy = clamp32((h * 65536 - 65536 - ny * h) >>> 1);
        r.sx = sx[31:0];
        r.sy = sy[31:0];
        r.behind = 1'b0;
        r.on_scr = within_view(sx, w) && within_view(sy, h);
        return r;
    endfunction

    task automatic write_reg(wtsp_pkg::t_cfg_idx idx, logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx <= wtsp_pkg::CFG_ROW_D_B) matrix_regs[idx] = data;
        else if (idx == wtsp_pkg::CFG_WIDTH) view_w = data[13:0];
        else view_h = data[13:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.world_x <= wx;
        pt_if.world_y <= wy;
        pt_if.world_z <= wz;
        pixel_queue.push_back(project_point(wx, wy, wz));
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        pt_if.valid <= 1'b0;
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n)
            pix_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel exp_pix;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            got = {pix_if.screen_x, pix_if.screen_y, pix_if.behind_camera,
                   pix_if.on_screen};
            if (pixel_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: %h", got);
            end else begin
                exp_pix = pixel_queue.pop_front();
                if (got !== exp_pix) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected x=%h y=%h b=%b on=%b, ",
                                  "got x=%h y=%h b=%b on=%b"},
                                 exp_pix.sx, exp_pix.sy, exp_pix.behind, exp_pix.on_scr,
                                 got.sx, got.sy, got.behind, got.on_scr);
                end
            end
        end
    end

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return 32'h0001_0000;
            default: return '0;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            default: return 32'($signed($urandom_range(20971520)) - 10485760);
        endcase
    endfunction

    task automatic load_camera(logic [31:0] depth_off);
        write_reg(wtsp_pkg::CFG_ROW_X_A, {32'h0, 32'h0001_0000});
        write_reg(wtsp_pkg::CFG_ROW_X_B, 64'h0);
        write_reg(wtsp_pkg::CFG_ROW_Y_A, {32'h0001_0000, 32'h0});
        write_reg(wtsp_pkg::CFG_ROW_Y_B, 64'h0);
        write_reg(wtsp_pkg::CFG_ROW_D_A, 64'h0);
        write_reg(wtsp_pkg::CFG_ROW_D_B, {depth_off, 32'h0001_0000});
    endtask

    task automatic test_reset_defaults();
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        end_burst();
    endtask

    task automatic test_directed_extremes();
        load_camera(32'h0);
        write_reg(wtsp_pkg::CFG_WIDTH, 64'd1920);
        write_reg(wtsp_pkg::CFG_HEIGHT, 64'd1080);
        send_point(32'h0, 32'h0, 32'h0001_0000);
        send_point(32'h0, 32'h0, 32'h0000_1999);
        send_point(32'h0, 32'h0, 32'h0000_199A);
        send_point(32'h0, 32'h0, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_199A);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_199A);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
        send_point(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        end_burst();
        write_reg(wtsp_pkg::CFG_WIDTH, 64'd8192);
        write_reg(wtsp_pkg::CFG_HEIGHT, 64'd1);
        send_point(32'h0000_8000, 32'h0000_8000, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        end_burst();
        write_reg(wtsp_pkg::CFG_WIDTH, 64'd0);
        write_reg(wtsp_pkg::CFG_HEIGHT, 64'h3FFF);
        send_point(32'h0, 32'h0, 32'h0001_0000);
        end_burst();
        write_reg(wtsp_pkg::CFG_ROW_X_A, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(wtsp_pkg::CFG_ROW_X_B, 64'h8000_0000_7FFF_FFFF);
        write_reg(wtsp_pkg::CFG_ROW_Y_A, 64'h8000_0000_8000_0000);
        write_reg(wtsp_pkg::CFG_ROW_Y_B, 64'h7FFF_FFFF_8000_0000);
        write_reg(wtsp_pkg::CFG_ROW_D_A, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(wtsp_pkg::CFG_ROW_D_B, 64'h7FFF_FFFF_7FFF_FFFF);
        write_reg(wtsp_pkg::CFG_WIDTH, 64'd1);
        write_reg(wtsp_pkg::CFG_HEIGHT, 64'd8192);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
        end_burst();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int n_items);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if ($urandom_range(1)) begin
            load_camera(32'($signed($urandom_range(262144)) - 131072));
        end else begin
            write_reg(wtsp_pkg::CFG_ROW_X_A, {rand_coef(), rand_coef()});
            write_reg(wtsp_pkg::CFG_ROW_X_B, {rand_coef(), rand_coef()});
            write_reg(wtsp_pkg::CFG_ROW_Y_A, {rand_coef(), rand_coef()});
            write_reg(wtsp_pkg::CFG_ROW_Y_B, {rand_coef(), rand_coef()});
            write_reg(wtsp_pkg::CFG_ROW_D_A, {rand_coef(), rand_coef()});
            write_reg(wtsp_pkg::CFG_ROW_D_B, {rand_coef(), rand_coef()});
        end
        write_reg(wtsp_pkg::CFG_WIDTH, 64'($urandom_range(8192, 1)));
        write_reg(wtsp_pkg::CFG_HEIGHT, 64'($urandom_range(8192, 1)));
        repeat (n_items) send_point(rand_coord(), rand_coord(), rand_coord());
        end_burst();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        foreach (matrix_regs[i]) matrix_regs[i] = '0;
        view_w = 14'd1920;
        view_h = 14'd1080;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_extremes();
        for (int k = 0; k < 3; k++) begin
            test_random_phase(0, 0, 50);
            test_random_phase(70, 0, 50);
            test_random_phase(0, 70, 50);
            test_random_phase(7, 7, 50);
        end
        if (mismatch_count == 0 && pixel_queue.size() == 0)
            $display("world_to_screen_projection_top_tb: done, clean");
        else
            $display("world_to_screen_projection_top_tb: done, errors");
        $finish;
    end

    initial begin
        #5ms;
        $display("world_to_screen_projection_top_tb: done, errors");
        $finish;
    end
endmodule
